// ----- hdl/uqpsd_pkg.sv -----
package uqpsd_pkg;

  localparam int MAX_PAIRS   = 32;
  localparam int BYTE_BUDGET = 8192;
  localparam int MAX_RES     = 6;

  localparam int PAIR_W   = $clog2(MAX_PAIRS + 1);
  localparam int BUDGET_W = $clog2(BYTE_BUDGET + 1);
  localparam int RES_W    = $clog2(MAX_RES + 1);
  localparam int SUB_W    = $clog2(MAX_RES);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [2:0] EV_NAME_BYTE  = 3'd0;
  localparam logic [2:0] EV_VALUE_BYTE = 3'd1;
  localparam logic [2:0] EV_NAME_END   = 3'd2;
  localparam logic [2:0] EV_PAIR_DONE  = 3'd3;
  localparam logic [2:0] EV_OVERFLOW   = 3'd4;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] decoded_byte;
    logic [4:0] pair_number;
    logic       run_last;
  } out_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [4:0] pair;
  } ev_t;

  // all results caused by one input word
  typedef struct packed {
    logic [RES_W-1:0]       cnt;
    ev_t  [MAX_RES-1:0]     ev;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- hdl/uqpsd_front.sv -----
module uqpsd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  uqpsd_pkg::in_t     in_word,
  output logic               push,
  output uqpsd_pkg::bundle_t bundle
);

  localparam logic [2:0] M_NAME_START = 3'd0;
  localparam logic [2:0] M_NAME       = 3'd1;
  localparam logic [2:0] M_VALUE      = 3'd2;
  localparam logic [2:0] M_SKIP       = 3'd3;
  localparam logic [2:0] M_IGNORE     = 3'd4;

  typedef struct packed {
    logic [2:0]                     mode;
    logic [1:0]                     hc;
    logic [7:0]                     digit;
    logic [uqpsd_pkg::PAIR_W-1:0]   pd;
    logic [uqpsd_pkg::BUDGET_W-1:0] bu;
    uqpsd_pkg::bundle_t             b;
  } st_t;

  logic [2:0]                     mode_r, mode_nxt;
  logic [1:0]                     hc_r, hc_nxt;
  logic [7:0]                     digit_r, digit_nxt;
  logic [uqpsd_pkg::PAIR_W-1:0]   pd_r, pd_nxt;
  logic [uqpsd_pkg::BUDGET_W-1:0] bu_r, bu_nxt;
  st_t                            st;

  function automatic logic hex_ok(logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic [3:0] hex_v(logic [7:0] c);
    logic [3:0] v;
    if (c inside {[8'h30:8'h39]}) v = 4'(c - 8'h30);
    else if (c inside {[8'h41:8'h46]}) v = 4'(c - 8'h37);
    else v = 4'(c - 8'h57);
    return v;
  endfunction

  function automatic st_t emit(st_t s, logic [2:0] kind, logic [7:0] d);
    st_t r;
    r = s;
    if (r.b.cnt < uqpsd_pkg::RES_W'(uqpsd_pkg::MAX_RES)) begin
      r.b.ev[uqpsd_pkg::SUB_W'(r.b.cnt)] = '{kind: kind, data: d, pair: 5'(r.pd)};
      r.b.cnt = r.b.cnt + 1'b1;
    end
    return r;
  endfunction

  function automatic st_t put(st_t s, logic [2:0] kind, logic [7:0] d);
    st_t r;
    r = s;
    if (s.mode != M_IGNORE) begin
      if (s.bu >= uqpsd_pkg::BUDGET_W'(uqpsd_pkg::BYTE_BUDGET)) begin
        r = emit(r, uqpsd_pkg::EV_OVERFLOW, 8'h00);
        r.mode  = M_IGNORE;
        r.hc    = 2'd0;
        r.digit = 8'h00;
      end else begin
        r.bu = s.bu + 1'b1;
        r = emit(r, kind, d);
      end
    end
    return r;
  endfunction

  function automatic st_t lit(st_t s, logic [7:0] c);
    return put(s, (s.mode == M_VALUE) ? uqpsd_pkg::EV_VALUE_BYTE : uqpsd_pkg::EV_NAME_BYTE, c);
  endfunction

  function automatic st_t flush(st_t s);
    st_t r;
    r = s;
    r.hc    = 2'd0;
    r.digit = 8'h00;
    if (s.hc >= 2'd1) r = lit(r, uqpsd_pkg::CH_PCT);
    if (s.hc == 2'd2) r = lit(r, s.digit);
    return r;
  endfunction

  function automatic st_t finish(st_t s);
    st_t r;
    r = put(s, uqpsd_pkg::EV_PAIR_DONE, 8'h00);
    if (r.mode != M_IGNORE) begin
      r.pd = r.pd + 1'b1;
      r.mode = (r.pd >= uqpsd_pkg::PAIR_W'(uqpsd_pkg::MAX_PAIRS)) ? M_IGNORE : M_NAME_START;
    end
    return r;
  endfunction

  function automatic st_t plain(st_t s, logic [7:0] c);
    st_t r;
    r = s;
    if (c == uqpsd_pkg::CH_PCT) r.hc = 2'd1;
    else if (c == uqpsd_pkg::CH_PLUS) r = lit(r, uqpsd_pkg::CH_SPACE);
    else r = lit(r, c);
    return r;
  endfunction

  function automatic st_t terminator(st_t s, logic [7:0] c);
    st_t r;
    r = s;
    case (s.mode)
      M_NAME_START: begin
        if (c == uqpsd_pkg::CH_EQ) r.mode = M_SKIP;
      end
      M_NAME: begin
        r = put(r, uqpsd_pkg::EV_NAME_END, 8'h00);
        if (r.mode != M_IGNORE) begin
          if (c == uqpsd_pkg::CH_EQ) r.mode = M_VALUE;
          else r = finish(r);
        end
      end
      M_VALUE: r = finish(r);
      default: r = s;
    endcase
    return r;
  endfunction

  function automatic st_t data_step(st_t s, logic [7:0] c);
    st_t  r;
    logic term;
    r = s;
    term = (c == uqpsd_pkg::CH_AMP) || (c == uqpsd_pkg::CH_EQ && s.mode != M_VALUE);
    if (s.mode == M_IGNORE) begin
      r = s;
    end else if (s.mode == M_SKIP) begin
      if (c == uqpsd_pkg::CH_AMP) r.mode = M_NAME_START;
    end else if (term) begin
      r = flush(r);
      if (r.mode != M_IGNORE) r = terminator(r, c);
    end else begin
      if (r.mode == M_NAME_START) r.mode = M_NAME;
      if (r.hc == 2'd1 && hex_ok(c)) begin
        r.digit = c;
        r.hc    = 2'd2;
      end else if (r.hc == 2'd2 && hex_ok(r.digit) && hex_ok(c)) begin
        r.hc    = 2'd0;
        r.digit = 8'h00;
        r = lit(r, {hex_v(s.digit), hex_v(c)});
      end else if (r.hc != 2'd0) begin
        // bad escape: release the held bytes as literals, then decode anew
        r = flush(r);
        if (r.mode != M_IGNORE) r = plain(r, c);
      end else begin
        r = plain(r, c);
      end
    end
    return r;
  endfunction

  function automatic st_t end_query(st_t s);
    st_t r;
    r = flush(s);
    if (r.mode == M_NAME) begin
      r = put(r, uqpsd_pkg::EV_NAME_END, 8'h00);
      if (r.mode != M_IGNORE) r = finish(r);
    end else if (r.mode == M_VALUE) begin
      r = finish(r);
    end
    r.mode  = M_NAME_START;
    r.hc    = 2'd0;
    r.digit = 8'h00;
    r.pd    = '0;
    r.bu    = '0;
    return r;
  endfunction

  always_comb begin
    st       = '0;
    st.mode  = mode_r;
    st.hc    = hc_r;
    st.digit = digit_r;
    st.pd    = pd_r;
    st.bu    = bu_r;
    if (in_word.raw_byte != uqpsd_pkg::CH_NUL) st = data_step(st, in_word.raw_byte);
    if (in_word.raw_byte == uqpsd_pkg::CH_NUL || in_word.end_of_string) st = end_query(st);
  end

  always_comb begin
    mode_nxt  = mode_r;
    hc_nxt    = hc_r;
    digit_nxt = digit_r;
    pd_nxt    = pd_r;
    bu_nxt    = bu_r;
    if (accept) begin
      mode_nxt  = st.mode;
      hc_nxt    = st.hc;
      digit_nxt = st.digit;
      pd_nxt    = st.pd;
      bu_nxt    = st.bu;
    end
  end

  assign push   = accept && (st.b.cnt != '0);
  assign bundle = st.b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_NAME_START;
      hc_r    <= 2'd0;
      digit_r <= 8'h00;
      pd_r    <= '0;
      bu_r    <= '0;
    end else begin
      mode_r  <= mode_nxt;
      hc_r    <= hc_nxt;
      digit_r <= digit_nxt;
      pd_r    <= pd_nxt;
      bu_r    <= bu_nxt;
    end
  end

endmodule

// ----- hdl/uqpsd_fifo.sv -----
module uqpsd_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  uqpsd_pkg::bundle_t wr_data,
  input  logic               rd_en,
  output uqpsd_pkg::bundle_t rd_data,
  output uqpsd_pkg::q_stat_t stat
);

  uqpsd_pkg::bundle_t          mem [uqpsd_pkg::QDEPTH];
  logic [uqpsd_pkg::QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [uqpsd_pkg::QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [uqpsd_pkg::QCW-1:0]   cnt_r, cnt_nxt;
  logic                        do_wr, do_rd;

  assign stat.full  = (cnt_r == uqpsd_pkg::QCW'(uqpsd_pkg::QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr && !do_rd) cnt_nxt = cnt_r + 1'b1;
    else if (!do_wr && do_rd) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- hdl/uqpsd_back.sv -----
module uqpsd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  uqpsd_pkg::bundle_t head,
  input  uqpsd_pkg::q_stat_t stat,
  input  logic               pop,
  output logic               empty,
  output uqpsd_pkg::out_t    data,
  output logic               rd_en
);

  logic [uqpsd_pkg::SUB_W-1:0] sub_r, sub_nxt;
  logic                        last;
  logic                        take;

  assign last  = (uqpsd_pkg::RES_W'(sub_r) + 1'b1 == head.cnt);
  assign empty = stat.empty;
  assign take  = pop && !stat.empty;
  assign rd_en = take && last;

  assign data.event_kind   = head.ev[sub_r].kind;
  assign data.decoded_byte = head.ev[sub_r].data;
  assign data.pair_number  = head.ev[sub_r].pair;
  assign data.run_last     = last;

  always_comb begin
    sub_nxt = sub_r;
    // advance within the bundle, drop it after its last word
    if (take) sub_nxt = last ? '0 : sub_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r <= '0;
    end else begin
      sub_r <= sub_nxt;
    end
  end

endmodule

// ----- hdl/url_query_pair_splitter_decoder.sv -----
// The results of a byte are written into the result queue and read combinationally from its head on the out_ ports.
// Throughput: one input byte per cycle while in_full is low; each pop takes one result,
// up to six per byte, and a four-entry queue of per-byte result groups sets in_full.
// Reset: synchronous, active low; clears the parser state and empties the result queue.
module url_query_pair_splitter_decoder (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  uqpsd_pkg::in_t   in_data,
  output logic             out_empty,
  input  logic             out_pop,
  output uqpsd_pkg::out_t  out_data
);

  uqpsd_pkg::bundle_t bundle;
  uqpsd_pkg::bundle_t head;
  uqpsd_pkg::q_stat_t stat;
  logic               accept;
  logic               push;
  logic               rd_en;

  assign in_full = stat.full;
  assign accept  = in_push && !stat.full;

  uqpsd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_word (in_data),
    .push    (push),
    .bundle  (bundle)
  );

  uqpsd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_data (bundle),
    .rd_en   (rd_en),
    .rd_data (head),
    .stat    (stat)
  );

  uqpsd_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .head  (head),
    .stat  (stat),
    .pop   (out_pop),
    .empty (out_empty),
    .data  (out_data),
    .rd_en (rd_en)
  );

endmodule

// ----- test/tb_url_query_pair_splitter_decoder.sv -----
`timescale 1ns / 1ps

module tb_url_query_pair_splitter_decoder;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_WORDS   = 444;
  localparam int MAX_REPORTS    = 30;

  typedef enum int {PM_NAME_START, PM_NAME, PM_VALUE, PM_SKIP, PM_IGNORE} parse_mode_t;

  typedef struct {
    uqpsd_pkg::in_t  word;
    bit              typed;
    uqpsd_pkg::out_t ev;
  } stim_row_t;

  logic            clk;
  logic            rst_n;
  logic            in_push;
  logic            in_full;
  uqpsd_pkg::in_t  in_data;
  logic            out_empty;
  logic            out_pop;
  uqpsd_pkg::out_t out_data;

  url_query_pair_splitter_decoder uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // decoder state mirror
  parse_mode_t     pmode;
  logic [7:0]      held_digit;
  int              held_cnt;
  int              pairs_done;
  int              budget_used;
  uqpsd_pkg::out_t step_events[$];
  uqpsd_pkg::out_t expected_events[$];

  stim_row_t       directed_rows[$];
  uqpsd_pkg::out_t want;
  int              errors;
  int              reports;
  int              words_sent;
  int              results_checked;
  int              overflow_hits;
  int              limit_hits;
  int              idle_pct;
  int              stall_pct;
  int              quiet_cycles;
  int              hold_left;
  bit              hold_req;

  function automatic int hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void clear_held();
    held_cnt   = 0;
    held_digit = 8'h00;
  endfunction

  function automatic void put_event(logic [2:0] kind, logic [7:0] b);
    uqpsd_pkg::out_t ev;
    if (pmode == PM_IGNORE) return;
    if (budget_used + 1 > uqpsd_pkg::BYTE_BUDGET) begin
      ev = '{uqpsd_pkg::EV_OVERFLOW, 8'h00, pairs_done[4:0], 1'b0};
      if (step_events.size() < uqpsd_pkg::MAX_RES) step_events.push_back(ev);
      pmode = PM_IGNORE;
      clear_held();
      overflow_hits++;
      return;
    end
    budget_used++;
    ev = '{kind, b, pairs_done[4:0], 1'b0};
    if (step_events.size() < uqpsd_pkg::MAX_RES) step_events.push_back(ev);
  endfunction

  function automatic void put_literal(logic [7:0] c);
    put_event((pmode == PM_VALUE) ? uqpsd_pkg::EV_VALUE_BYTE : uqpsd_pkg::EV_NAME_BYTE, c);
  endfunction

  function automatic void flush_held();
    int         cnt;
    logic [7:0] d;
    cnt = held_cnt;
    d   = held_digit;
    clear_held();
    if (cnt >= 1) put_literal(uqpsd_pkg::CH_PCT);
    if (cnt == 2) put_literal(d);
  endfunction

  function automatic void close_pair();
    put_event(uqpsd_pkg::EV_PAIR_DONE, 8'h00);
    if (pmode == PM_IGNORE) return;
    pairs_done++;
    if (pairs_done >= uqpsd_pkg::MAX_PAIRS) begin
      pmode = PM_IGNORE;
      limit_hits++;
    end else begin
      pmode = PM_NAME_START;
    end
  endfunction

  function automatic void plain_byte(logic [7:0] c);
    if (c == uqpsd_pkg::CH_PCT) begin
      held_cnt = 1;
    end else if (c == uqpsd_pkg::CH_PLUS) begin
      put_literal(uqpsd_pkg::CH_SPACE);
    end else begin
      put_literal(c);
    end
  endfunction

  function automatic void at_terminator(logic [7:0] c);
    if (pmode == PM_NAME_START) begin
      if (c == uqpsd_pkg::CH_EQ) pmode = PM_SKIP;
    end else if (pmode == PM_NAME) begin
      put_event(uqpsd_pkg::EV_NAME_END, 8'h00);
      if (pmode == PM_IGNORE) return;
      if (c == uqpsd_pkg::CH_EQ) pmode = PM_VALUE;
      else close_pair();
    end else if (pmode == PM_VALUE) begin
      close_pair();
    end
  endfunction

  function automatic void data_byte(logic [7:0] c);
    bit term;
    int hi;
    int lo;
    if (pmode == PM_IGNORE) return;
    if (pmode == PM_SKIP) begin
      if (c == uqpsd_pkg::CH_AMP) pmode = PM_NAME_START;
      return;
    end
    term = (c == uqpsd_pkg::CH_AMP) || (c == uqpsd_pkg::CH_EQ && pmode != PM_VALUE);
    if (term) begin
      flush_held();
      if (pmode != PM_IGNORE) at_terminator(c);
      return;
    end
    if (pmode == PM_NAME_START) pmode = PM_NAME;
    if (held_cnt == 1) begin
      if (hex_val(c) >= 0) begin
        held_digit = c;
        held_cnt   = 2;
        return;
      end
      flush_held();
      if (pmode == PM_IGNORE) return;
      plain_byte(c);
    end else if (held_cnt == 2) begin
      hi = hex_val(held_digit);
      lo = hex_val(c);
      if (lo >= 0) begin
        clear_held();
        put_literal(8'(hi * 16 + lo));
        return;
      end
      flush_held();
      if (pmode == PM_IGNORE) return;
      plain_byte(c);
    end else begin
      plain_byte(c);
    end
  endfunction

  function automatic void end_of_query();
    flush_held();
    if (pmode == PM_NAME) begin
      put_event(uqpsd_pkg::EV_NAME_END, 8'h00);
      if (pmode != PM_IGNORE) close_pair();
    end else if (pmode == PM_VALUE) begin
      close_pair();
    end
    pmode = PM_NAME_START;
    clear_held();
    pairs_done  = 0;
    budget_used = 0;
  endfunction

  function automatic void reset_decoder_state();
    pmode = PM_NAME_START;
    clear_held();
    pairs_done  = 0;
    budget_used = 0;
  endfunction

  function automatic void decode_query_byte(uqpsd_pkg::in_t w);
    step_events.delete();
    if (w.raw_byte != uqpsd_pkg::CH_NUL) data_byte(w.raw_byte);
    if (w.raw_byte == uqpsd_pkg::CH_NUL || w.end_of_string) end_of_query();
    if (step_events.size() > 0) step_events[step_events.size() - 1].run_last = 1'b1;
  endfunction

  function automatic void add_row(logic [7:0] b, bit eos, bit typed = 1'b0,
                                  uqpsd_pkg::out_t ev = '0);
    stim_row_t r;
    r.word  = '{b, eos};
    r.typed = typed;
    r.ev    = ev;
    directed_rows.push_back(r);
  endfunction

  task automatic push_word(input uqpsd_pkg::in_t w, input bit typed = 1'b0,
                           input uqpsd_pkg::out_t typed_ev = '0);
    @(negedge clk);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_full);
    decode_query_byte(w);
    if (typed) begin
      step_events.delete();
      step_events.push_back(typed_ev);
    end
    foreach (step_events[i]) expected_events.push_back(step_events[i]);
    words_sent++;
  endtask

  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'("0" + v);
    return 8'(($urandom_range(1) ? "a" : "A") + v - 10);
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while (hex_val(c) >= 0 || c == uqpsd_pkg::CH_AMP || c == uqpsd_pkg::CH_EQ);
    return c;
  endfunction

  task automatic add_segment(ref logic [7:0] q[$], input int len, input bit in_value);
    logic [7:0] c;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(39) == 0) begin
        q.push_back(8'($urandom_range(255)));
        continue;
      end
      case ($urandom_range(15))
        0: q.push_back(uqpsd_pkg::CH_PLUS);
        1, 2: begin
          q.push_back(uqpsd_pkg::CH_PCT);
          q.push_back(rand_hex());
          q.push_back(rand_hex());
        end
        3: q.push_back(uqpsd_pkg::CH_PCT);
        4: begin
          q.push_back(uqpsd_pkg::CH_PCT);
          q.push_back(rand_hex());
        end
        5: begin
          q.push_back(uqpsd_pkg::CH_PCT);
          q.push_back(rand_non_hex());
        end
        6: begin
          do c = 8'($urandom_range(1, 255));
          while (c == uqpsd_pkg::CH_AMP || (!in_value && c == uqpsd_pkg::CH_EQ));
          q.push_back(c);
        end
        7: q.push_back(in_value ? uqpsd_pkg::CH_EQ : 8'("a" + $urandom_range(25)));
        default: q.push_back($urandom_range(1) ? 8'("a" + $urandom_range(25))
                                                : 8'("0" + $urandom_range(9)));
      endcase
    end
  endtask

  // room caps the words of this query, terminator included
  task automatic send_query(input int room);
    logic [7:0]     bytes[$];
    int             npairs;
    int             style;
    int             key_len;
    bit             with_value;
    uqpsd_pkg::in_t w;
    if ($urandom_range(9) == 0) begin
      // pure noise
      repeat ($urandom_range(1, 20)) bytes.push_back(8'($urandom_range(255)));
    end else begin
      npairs = ($urandom_range(7) == 0) ? $urandom_range(33, 36) : $urandom_range(0, 5);
      for (int i = 0; i < npairs; i++) begin
        if (i > 0) bytes.push_back(uqpsd_pkg::CH_AMP);
        // keep long queries short per pair so they reach the pair limit
        key_len = (npairs > 8) ? 1
                : ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 5);
        add_segment(bytes, key_len, 1'b0);
        with_value = (npairs > 8) ? ($urandom_range(7) == 0) : ($urandom_range(3) != 0);
        if (with_value) begin
          bytes.push_back(uqpsd_pkg::CH_EQ);
          add_segment(bytes, (npairs > 8) ? $urandom_range(0, 1) : $urandom_range(0, 6), 1'b1);
        end
      end
    end
    while (bytes.size() > room - 1) void'(bytes.pop_back());
    style = $urandom_range(3);
    foreach (bytes[i]) begin
      w.raw_byte      = bytes[i];
      w.end_of_string = (style >= 2) && (i == bytes.size() - 1);
      push_word(w);
    end
    if (style < 2 || bytes.size() == 0) begin
      w.raw_byte      = (style < 2) ? uqpsd_pkg::CH_NUL : 8'($urandom_range(1, 255));
      w.end_of_string = (style != 0);
      push_word(w);
    end
  endtask

  // receiver
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_pop <= 1'b0;
        hold_left = HOLD_CYCLES;
        while (hold_left > 0) begin
          @(negedge clk);
          hold_left--;
        end
        hold_req = 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      results_checked++;
      if (expected_events.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: unexpected word: kind %0d byte %h pair %0d last %b", $time,
                   out_data.event_kind, out_data.decoded_byte, out_data.pair_number,
                   out_data.run_last);
        end
      end else begin
        want = expected_events.pop_front();
        if (out_data.event_kind !== want.event_kind ||
            out_data.decoded_byte !== want.decoded_byte ||
            out_data.pair_number !== want.pair_number ||
            out_data.run_last !== want.run_last) begin
          errors++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: kind/byte/pair/last expected %0d %h %0d %b, got %0d %h %0d %b",
                     $time, want.event_kind, want.decoded_byte, want.pair_number,
                     want.run_last, out_data.event_kind, out_data.decoded_byte,
                     out_data.pair_number, out_data.run_last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d words still expected",
                 WATCHDOG_LIMIT, expected_events.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int target;
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_data      = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_req     = 1'b0;
    quiet_cycles = 0;
    reset_decoder_state();

    add_row("a", 1'b0, 1'b1, '{uqpsd_pkg::EV_NAME_BYTE, "a", 5'd0, 1'b1});
    add_row(8'hFF, 1'b0, 1'b1, '{uqpsd_pkg::EV_NAME_BYTE, 8'hFF, 5'd0, 1'b1});
    add_row(uqpsd_pkg::CH_EQ, 1'b0, 1'b1, '{uqpsd_pkg::EV_NAME_END, 8'h00, 5'd0, 1'b1});
    add_row(uqpsd_pkg::CH_PLUS, 1'b0, 1'b1,
            '{uqpsd_pkg::EV_VALUE_BYTE, uqpsd_pkg::CH_SPACE, 5'd0, 1'b1});
    add_row(uqpsd_pkg::CH_PCT, 1'b0);
    add_row("4", 1'b0);
    add_row("1", 1'b0, 1'b1, '{uqpsd_pkg::EV_VALUE_BYTE, 8'h41, 5'd0, 1'b1});
    add_row(uqpsd_pkg::CH_EQ, 1'b0, 1'b1,
            '{uqpsd_pkg::EV_VALUE_BYTE, uqpsd_pkg::CH_EQ, 5'd0, 1'b1});
    add_row(uqpsd_pkg::CH_PCT, 1'b0);
    add_row("g", 1'b0);
    add_row(uqpsd_pkg::CH_PCT, 1'b0);
    add_row("f", 1'b0);
    add_row(uqpsd_pkg::CH_AMP, 1'b0);
    // empty name: "=x" is skipped up to the next separator
    add_row(uqpsd_pkg::CH_EQ, 1'b0);
    add_row("x", 1'b0);
    add_row(uqpsd_pkg::CH_AMP, 1'b0);
    add_row("b", 1'b0, 1'b1, '{uqpsd_pkg::EV_NAME_BYTE, "b", 5'd1, 1'b1});
    add_row(uqpsd_pkg::CH_PCT, 1'b0);
    add_row(uqpsd_pkg::CH_NUL, 1'b0);
    add_row(uqpsd_pkg::CH_PCT, 1'b0);
    add_row("A", 1'b1);
    add_row(uqpsd_pkg::CH_AMP, 1'b1);
    add_row(uqpsd_pkg::CH_PCT, 1'b0);
    add_row("e", 1'b0);
    add_row("z", 1'b1);
    add_row(8'h01, 1'b1);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      push_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].ev);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
          hold_req  = 1'b1;
        end
        1: begin
          idle_pct  = 78;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 78;
        end
        default: begin
          idle_pct  = 8;
          stall_pct = 8;
        end
      endcase
      target = words_sent + RANDOM_WORDS / 4;
      while (words_sent < target) send_query(target - words_sent);
    end

    @(negedge clk);
    in_push  <= 1'b0;
    stall_pct = 0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d input words and %0d result words; %0d budget overflows, %0d pair-limit hits",
             words_sent, results_checked, overflow_hits, limit_hits);
    $display("idle mixes: none, sender 78%%, receiver 78%%, both 8%%; one receiver hold of %0d cycles",
             HOLD_CYCLES);
    if (errors == 0 && expected_events.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d errors, %0d words never arrived", errors, expected_events.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- url_query_pair_splitter_decoder.f -----
hdl/uqpsd_pkg.sv
hdl/uqpsd_front.sv
hdl/uqpsd_fifo.sv
hdl/uqpsd_back.sv
hdl/url_query_pair_splitter_decoder.sv
test/tb_url_query_pair_splitter_decoder.sv
